@@ rtl/core/npsc_pkg.sv @@
// Shared types and constants for the neighbor pair state counter.
package npsc_pkg;

	// Item operation codes
	localparam logic OP_SITE = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Configuration register indexes
	localparam logic REG_MIN_DEPTH   = 1'b0;
	localparam logic REG_WINDOW_SIZE = 1'b1;

	// Field widths
	localparam int SITE_W  = 12;
	localparam int COUNT_W = 32;
	localparam int OFF_W   = 3;
	localparam int CNT_W   = 16;
	localparam int ENTRY_W = 4 * CNT_W;
	localparam int WIN_W   = 4;

	// Reset values of the configuration registers
	localparam logic [COUNT_W-1:0] MIN_DEPTH_RST   = 32'd1;
	localparam logic [WIN_W-1:0]   WINDOW_SIZE_RST = 4'd5;

	// Per-site classification
	typedef struct packed {
		logic ok;
		logic decisive;
		logic low;
	} site_class_t;

	// Command to the counter memory
	typedef struct packed {
		logic       valid;
		logic       bump;
		logic [1:0] lane;
	} ram_cmd_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASS,
		ST_PAIR,
		ST_READ,
		ST_RESP
	} seq_state_t;

endpackage

@@ rtl/core/npsc_site_class.sv @@
// Two-stage site classifier: depth check, decisive test and low flag.
module npsc_site_class
	import npsc_pkg::*;
(
	input  logic               clk,
	input  logic               load,
	input  logic [COUNT_W-1:0] meth_count,
	input  logic [COUNT_W-1:0] unmeth_count,
	input  logic [COUNT_W-1:0] min_depth,
	output site_class_t        site_class
);

	logic [COUNT_W:0]   total_s1;
	logic [COUNT_W-1:0] diff_s1;
	logic               low_s1;
	site_class_t        class_s2;
	logic [COUNT_W+2:0] diff_x5;
	logic [COUNT_W+2:0] total_x2;

	// Stage 1: form depth and absolute difference
	always_ff @(posedge clk) begin
		if (load) begin
			total_s1 <= {1'b0, meth_count} + {1'b0, unmeth_count};
			low_s1   <= meth_count < unmeth_count;
			diff_s1  <= (meth_count < unmeth_count) ? (unmeth_count - meth_count)
			                                        : (meth_count - unmeth_count);
		end
	end

	// Stage 2: compare 5*|M-U| against 2*(M+U) and depth against the minimum
	assign diff_x5  = {diff_s1, 2'b00} + {3'b000, diff_s1};
	assign total_x2 = {1'b0, total_s1, 1'b0};

	always_ff @(posedge clk) begin
		class_s2.ok       <= (total_s1 != '0) && (total_s1 >= {1'b0, min_depth});
		class_s2.decisive <= diff_x5 >= total_x2;
		class_s2.low      <= low_s1;
	end

	assign site_class = class_s2;

endmodule

@@ rtl/core/npsc_pair_ram.sv @@
// Pair counter memory: clearing sweep, saturating read-modify-write and reads.
module npsc_pair_ram
	import npsc_pkg::*;
#(
	parameter int DEPTH = 32768,
	parameter int AW    = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ram_cmd_t           cmd,
	input  logic [AW-1:0]      cmd_addr,
	output logic               busy,
	output logic               rd_valid,
	output logic [ENTRY_W-1:0] rd_data
);

	logic [ENTRY_W-1:0] mem [DEPTH];

	logic               clr_q;
	logic [AW-1:0]      clr_addr_q;
	ram_cmd_t           cmd_s1;
	logic [AW-1:0]      addr_s1;
	logic [ENTRY_W-1:0] rd_s1;
	logic               fwd_s1;
	logic [ENTRY_W-1:0] wdat_q;
	logic [ENTRY_W-1:0] cur_entry;
	logic [ENTRY_W-1:0] new_entry;
	logic [CNT_W-1:0]   lane_val;
	logic               wr_en;

	// Clear every entry once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	assign busy = clr_q;

	// Command stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
			fwd_s1 <= 1'b0;
		end else begin
			cmd_s1 <= cmd;
			fwd_s1 <= cmd.valid && wr_en && (cmd_addr == addr_s1);
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= cmd_addr;
		wdat_q  <= new_entry;
	end

	// Forward the entry being written when the next access hits it
	assign cur_entry = fwd_s1 ? wdat_q : rd_s1;

	// Saturating increment of the selected lane
	always_comb begin
		new_entry = cur_entry;
		lane_val  = cur_entry[cmd_s1.lane*CNT_W +: CNT_W];
		if (lane_val != '1) begin
			new_entry[cmd_s1.lane*CNT_W +: CNT_W] = lane_val + 1'b1;
		end
	end

	assign wr_en = cmd_s1.valid && cmd_s1.bump;

	// Memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[addr_s1] <= new_entry;
		end
		rd_s1 <= mem[cmd_addr];
	end

	assign rd_valid = cmd_s1.valid && !cmd_s1.bump;
	assign rd_data  = cur_entry;

endmodule

@@ rtl/core/neighbor_pair_state_counter_unit.sv @@
// A site item passes ST_CLASS, then ST_PAIR for distances 1 to max(win,1), where win is window_size
// clamped to MAX_WINDOW; a read passes ST_READ, waiting for a free result register, then ST_RESP.
// Items are taken only in ST_IDLE; after the sweep the memory takes one read-modify-write per cycle.
// Reset: arst_n clears control state and the recent-site slots, then a sweep zeroes all
// MAX_SITES*MAX_WINDOW counter memory entries while item_stall stays high.
// Configuration writes are taken at any time, including during the sweep.
module neighbor_pair_state_counter_unit
	import npsc_pkg::*;
#(
	parameter int MAX_SITES  = 4096,
	parameter int MAX_WINDOW = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               write_en,
	input  logic               reg_index,
	input  logic [COUNT_W-1:0] write_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               op,
	input  logic [SITE_W-1:0]  site_index,
	input  logic [COUNT_W-1:0] meth_count,
	input  logic [COUNT_W-1:0] unmeth_count,
	input  logic [OFF_W-1:0]   neighbor_offset,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [CNT_W-1:0]   both_unmeth,
	output logic [CNT_W-1:0]   first_unmeth_second_meth,
	output logic [CNT_W-1:0]   first_meth_second_unmeth,
	output logic [CNT_W-1:0]   both_meth
);

	localparam int DEPTH = MAX_SITES * MAX_WINDOW;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = $clog2(MAX_WINDOW + 1);
	localparam int IW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	logic [COUNT_W-1:0] min_depth_q;
	logic [WIN_W-1:0]   window_size_q;
	seq_state_t         state_q, state_d;
	site_class_t        recent_q [MAX_WINDOW];
	site_class_t        cur_class;
	site_class_t        prev_class;
	logic [SITE_W-1:0]  site_q;
	logic [OFF_W-1:0]   off_q;
	logic [DW-1:0]      d_q;
	logic [DW-1:0]      win;
	logic [4:0]         win_full;
	logic [SITE_W-1:0]  target;
	logic               pair_hit;
	logic               rd_in_range;
	logic [AW-1:0]      pair_addr;
	logic [AW-1:0]      read_addr;
	logic               rd_zero_q;
	logic               item_xfer;
	logic               out_free;
	ram_cmd_t           ram_cmd;
	logic [AW-1:0]      ram_addr;
	logic               ram_busy;
	logic               ram_rd_valid;
	logic [ENTRY_W-1:0] ram_rd_data;
	logic               result_valid_q;
	logic [ENTRY_W-1:0] result_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_depth_q   <= MIN_DEPTH_RST;
			window_size_q <= WINDOW_SIZE_RST;
		end else if (write_en) begin
			unique case (reg_index)
				REG_MIN_DEPTH:   min_depth_q   <= write_data;
				REG_WINDOW_SIZE: window_size_q <= write_data[WIN_W-1:0];
				default:         min_depth_q   <= min_depth_q;
			endcase
		end
	end

	assign item_stall = (state_q != ST_IDLE) || ram_busy;
	assign item_xfer  = item_valid && !item_stall;
	assign out_free   = !result_valid_q || !result_stall;

	// Classify the incoming site
	npsc_site_class u_class (
		.clk          (clk),
		.load         (item_xfer),
		.meth_count   (meth_count),
		.unmeth_count (unmeth_count),
		.min_depth    (min_depth_q),
		.site_class   (cur_class)
	);

	// Clamp the window to the slots held
	assign win_full = ({1'b0, window_size_q} > 5'(MAX_WINDOW)) ? 5'(MAX_WINDOW)
	                                                          : {1'b0, window_size_q};
	assign win      = DW'(win_full);

	// Pair test for distance d_q
	assign prev_class = recent_q[IW'(d_q - 1'b1)];
	assign target     = site_q - SITE_W'(d_q);
	assign pair_hit   = prev_class.ok && cur_class.ok
	                 && (prev_class.decisive || cur_class.decisive)
	                 && (32'(site_q) >= 32'(d_q))
	                 && (32'(target) < 32'(MAX_SITES));
	assign pair_addr  = AW'(32'(target) * 32'(MAX_WINDOW) + 32'(d_q) - 32'd1);

	// Read address and range check
	assign rd_in_range = (32'(site_q) < 32'(MAX_SITES)) && (32'(off_q) < 32'(MAX_WINDOW));
	assign read_addr   = AW'(32'(site_q) * 32'(MAX_WINDOW) + 32'(off_q));

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory commands
	always_comb begin
		state_d  = state_q;
		ram_cmd  = '0;
		ram_addr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_xfer) begin
					state_d = (op == OP_READ) ? ST_READ : ST_CLASS;
				end
			end
			ST_CLASS: begin
				state_d = ST_PAIR;
			end
			ST_PAIR: begin
				if ((d_q <= win) && pair_hit) begin
					ram_cmd.valid = 1'b1;
					ram_cmd.bump  = 1'b1;
					ram_cmd.lane  = {prev_class.low, cur_class.low};
					ram_addr      = pair_addr;
				end
				if (d_q >= win) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				if (out_free) begin
					ram_cmd.valid = 1'b1;
					ram_addr      = read_addr;
					state_d       = ST_RESP;
				end
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold item fields and step the distance counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= '0;
		end else if (state_q == ST_CLASS) begin
			d_q <= DW'(1);
		end else if (state_q == ST_PAIR) begin
			d_q <= d_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			site_q <= site_index;
			off_q  <= neighbor_offset;
		end
		if (state_q == ST_READ) begin
			rd_zero_q <= !rd_in_range;
		end
	end

	// Recent site slots: clear when site 0 arrives, advance when a site is done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				recent_q[i] <= '0;
			end
		end else if (item_xfer && (op == OP_SITE) && (site_index == '0)) begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				recent_q[i] <= '0;
			end
		end else if ((state_q == ST_PAIR) && (d_q >= win)) begin
			for (int i = MAX_WINDOW - 1; i > 0; i--) begin
				recent_q[i] <= recent_q[i-1];
			end
			recent_q[0] <= cur_class;
		end
	end

	// Counter memory
	npsc_pair_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ram_cmd),
		.cmd_addr (ram_addr),
		.busy     (ram_busy),
		.rd_valid (ram_rd_valid),
		.rd_data  (ram_rd_data)
	);

	// Result register: load on read data, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ram_rd_valid) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_rd_valid) begin
			result_q <= rd_zero_q ? '0 : ram_rd_data;
		end
	end

	assign result_valid             = result_valid_q;
	assign both_unmeth              = result_q[4*CNT_W-1:3*CNT_W];
	assign first_unmeth_second_meth = result_q[3*CNT_W-1:2*CNT_W];
	assign first_meth_second_unmeth = result_q[2*CNT_W-1:CNT_W];
	assign both_meth                = result_q[CNT_W-1:0];

	// No memory command while the clearing sweep runs
	a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ram_busy |-> !ram_cmd.valid)
		else $error("memory command during clearing sweep");

	// Read data only arrives in the response state
	a_rd_in_resp: assert property (@(posedge clk) disable iff (!arst_n)
		ram_rd_valid |-> (state_q == ST_RESP))
		else $error("read data outside response state");

	// A new result follows a read command, through the command stage register and the result register
	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(ram_cmd.valid && !ram_cmd.bump, 2))
		else $error("result without a preceding read");

	// The distance counter stays between 1 and MAX_WINDOW while pairing
	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAIR) |-> ((d_q >= DW'(1)) && (32'(d_q) <= 32'(MAX_WINDOW))))
		else $error("pair distance out of range");

endmodule
